/* rtl/edd_pkg.sv */
// Shared constants for the error diffusion dither block.
package edd_pkg;

  // Configuration register indexes.
  localparam logic [1:0] RegImageWidth  = 2'd0;
  localparam logic [1:0] RegImageHeight = 2'd1;
  localparam logic [1:0] RegThreshold   = 2'd2;

  // Register reset values.
  localparam logic [7:0] WidthReset     = 8'd128;
  localparam logic [7:0] HeightReset    = 8'd64;
  localparam logic [7:0] ThresholdReset = 8'd128;

  // Field widths.
  localparam int GrayW = 8;
  localparam int ErrW  = 10;
  localparam int SumW  = 12;
  localparam int ProdW = 14;
  localparam int ColW  = 7;
  localparam int RowW  = 8;

  // Error shares in sixteenths.
  localparam logic signed [ProdW-1:0] ShareRight     = 14'sd7;
  localparam logic signed [ProdW-1:0] ShareBelowLeft = 14'sd3;
  localparam logic signed [ProdW-1:0] ShareBelow     = 14'sd5;
  localparam int ShareShift = 4;

  localparam logic [GrayW-1:0] PixMax = 8'd255;

endpackage

/* rtl/error_diffusion_dither_top.sv */
// Floyd-Steinberg error diffusion dither with a line buffer of row errors.
//
// Gray pixels arrive in raster order as beats on the slave stream; each one
// gives exactly one beat on the master stream with the binary dot, the
// pixel's column and row, and tlast on the final pixel of the image.
// The user sets width, height and threshold via the write port only while
// the block is idle, not enforced here; a write acts where cfg_we_i is high.
//
// An accepted input beat is registered into the arithmetic stage with its
// line buffer read; the error arithmetic then goes into the output register.
// Throughput is one pixel per clock while the receiver takes every beat, set
// by the single read-modify-write of the line buffer per pixel. The buffer
// has one write port; the extra write at a row end is held in a register and
// goes out before the next pixel's writes, a row start with no left write.
// Recent writes are forwarded to a read of the same entry.
//
// Reset clears the counters, the carried errors and the pipeline; the
// line buffer is not cleared, since row 0 never uses it. When the receiver
// stalls, the output register holds its beat, the arithmetic stage holds one
// more pixel, and s_axis_tready falls until the output beat is taken.
module error_diffusion_dither_top #(
  parameter int MaxWidth = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write port.
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_addr_i,
  input  logic [7:0] cfg_data_i,
  // Input stream. tdata: gray [7:0].
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  // Output stream. tdata: dot [0], column [7:1], row [15:8].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import edd_pkg::*;

  localparam int AddrW = $clog2(MaxWidth);
  localparam int CmpW  = (AddrW + 1 > 8) ? AddrW + 1 : 8;

  // Configuration registers.
  logic [7:0] width_q, height_q, thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      thresh_q <= ThresholdReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegImageWidth:  width_q  <= cfg_data_i;
        RegImageHeight: height_q <= cfg_data_i;
        RegThreshold:   thresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Position counters, advanced when a pixel is accepted.
  logic [AddrW-1:0] col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [CmpW-1:0]  w_eff;
  logic [RowW-1:0]  h_eff;
  logic             in_row_end, in_img_end, accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    w_eff = CmpW'(width_q);
    if (width_q == 8'd0) begin
      w_eff = CmpW'(1);
    end else if (CmpW'(width_q) > CmpW'(MaxWidth)) begin
      w_eff = CmpW'(MaxWidth);
    end
    h_eff = (height_q == 8'd0) ? 8'd1 : height_q;
    in_row_end = (CmpW'(col_q) + CmpW'(1)) >= w_eff;
    in_img_end = in_row_end && (row_q >= (h_eff - 8'd1));
    col_d = in_row_end ? '0 : col_q + AddrW'(1);
    row_d = row_q;
    if (in_row_end) begin
      row_d = in_img_end ? '0 : row_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Arithmetic stage: holds one pixel with its registered line buffer read.
  logic             s1_valid_q, s1_adv;
  logic [GrayW-1:0] s1_gray_q;
  logic [AddrW-1:0] s1_col_q;
  logic [RowW-1:0]  s1_row_q;
  logic             s1_row_end_q, s1_img_end_q;
  logic             out_valid_q;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_gray_q    <= s_axis_tdata;
      s1_col_q     <= col_q;
      s1_row_q     <= row_q;
      s1_row_end_q <= in_row_end;
      s1_img_end_q <= in_img_end;
    end
  end

  // Line buffer of errors for the next row.
  logic signed [ErrW-1:0] line_mem [MaxWidth];
  logic signed [ErrW-1:0] rd_data_q;
  logic                   port_we;
  logic [AddrW-1:0]       port_addr;
  logic signed [ErrW-1:0] port_data;

  always_ff @(posedge clk_i) begin
    if (port_we) begin
      line_mem[port_addr] <= port_data;
    end
    if (accept) begin
      rd_data_q <= line_mem[col_q];
    end
  end

  // Forwarding of a write that lands on the entry of the waiting pixel.
  logic                   fwd_valid_q;
  logic signed [ErrW-1:0] fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (accept) begin
      fwd_valid_q <= port_we && (port_addr == col_q);
    end else if (s1_valid_q && port_we && (port_addr == s1_col_q)) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept || s1_valid_q) begin
      if (port_we && (port_addr == (accept ? col_q : s1_col_q))) begin
        fwd_data_q <= port_data;
      end
    end
  end

  // Carried errors and the held row-end write.
  logic signed [ErrW-1:0] right_q, right_d;
  logic signed [ErrW-1:0] pbl_q, pbl_d;
  logic signed [ErrW-1:0] pb_q, pb_d;
  logic                   hold_valid_q, hold_valid_d;
  logic [AddrW-1:0]       hold_addr_q;
  logic signed [ErrW-1:0] hold_data_q;

  logic signed [ErrW-1:0]  above;
  logic signed [SumW-1:0]  sum;
  logic [GrayW-1:0]        val;
  logic                    white, has_left, wr_left, wr_end;
  logic signed [ErrW-1:0]  err, e7, e3, e5, e1, left_data, end_data;
  logic signed [ProdW-1:0] err_x, p7, p3, p5, q7, q3, q5;

  always_comb begin
    if (hold_valid_q && (hold_addr_q == s1_col_q)) begin
      above = hold_data_q;
    end else if (fwd_valid_q) begin
      above = fwd_data_q;
    end else begin
      above = rd_data_q;
    end
    if (s1_row_q == '0) begin
      above = '0;
    end

    sum = $signed({{(SumW - GrayW){1'b0}}, s1_gray_q})
        + $signed({{(SumW - ErrW){right_q[ErrW-1]}}, right_q})
        + $signed({{(SumW - ErrW){above[ErrW-1]}}, above});
    if (sum < 0) begin
      val = '0;
    end else if (sum > $signed({{(SumW - GrayW){1'b0}}, PixMax})) begin
      val = PixMax;
    end else begin
      val = sum[GrayW-1:0];
    end

    white = val > thresh_q;
    err   = white ? $signed({2'b00, val}) - $signed({2'b00, PixMax})
                  : $signed({2'b00, val});
    err_x = $signed({{(ProdW - ErrW){err[ErrW-1]}}, err});
    p7 = err_x * ShareRight;
    p3 = err_x * ShareBelowLeft;
    p5 = err_x * ShareBelow;
    q7 = p7 >>> ShareShift;
    q3 = p3 >>> ShareShift;
    q5 = p5 >>> ShareShift;
    e7 = q7[ErrW-1:0];
    e3 = q3[ErrW-1:0];
    e5 = q5[ErrW-1:0];
    e1 = err >>> ShareShift;

    has_left  = s1_col_q != '0;
    left_data = pbl_q + e3;
    end_data  = pb_q + e5;
    wr_left   = s1_adv && has_left;
    wr_end    = s1_adv && s1_row_end_q;

    // The held write goes first; a row end with a left write is held.
    port_we      = hold_valid_q || wr_left || wr_end;
    port_addr    = s1_col_q;
    port_data    = end_data;
    hold_valid_d = 1'b0;
    if (hold_valid_q) begin
      port_addr    = hold_addr_q;
      port_data    = hold_data_q;
      hold_valid_d = wr_end;
    end else if (wr_left) begin
      port_addr    = s1_col_q - AddrW'(1);
      port_data    = left_data;
      hold_valid_d = wr_end;
    end

    right_d = s1_row_end_q ? '0 : e7;
    pbl_d   = s1_row_end_q ? '0 : end_data;
    pb_d    = s1_row_end_q ? '0 : e1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q      <= '0;
      pbl_q        <= '0;
      pb_q         <= '0;
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      if (s1_adv) begin
        right_q <= right_d;
        pbl_q   <= pbl_d;
        pb_q    <= pb_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_end) begin
      hold_addr_q <= s1_col_q;
      hold_data_q <= end_data;
    end
  end

  // Output register.
  logic            out_dot_q, out_last_q;
  logic [ColW-1:0] out_col_q;
  logic [RowW-1:0] out_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_dot_q  <= white;
      out_col_q  <= ColW'(s1_col_q);
      out_row_q  <= s1_row_q;
      out_last_q <= s1_img_end_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_row_q, out_col_q, out_dot_q};
  assign m_axis_tlast  = out_last_q;

endmodule
